FILE: hdl/stnp_pkg.sv
// Shared constants, token codes and command types of the source tokenizer.
`timescale 1ns / 1ps
package stnp_pkg;

    localparam int POOL_BYTES = 4096;
    localparam int POOL_AW    = $clog2(POOL_BYTES);
    localparam int FILL_W     = POOL_AW + 1;
    localparam int MAX_NAME   = 32;
    localparam int NAME_AW    = $clog2(MAX_NAME);
    localparam int LEN_W      = 6;

    localparam logic [62:0] NUM_MAX  = {63{1'b1}};
    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

    localparam logic [4:0] KIND_IDENT  = 5'd0;
    localparam logic [4:0] KIND_NUMBER = 5'd1;
    localparam logic [4:0] KIND_PLUS   = 5'd2;
    localparam logic [4:0] KIND_STAR   = 5'd3;
    localparam logic [4:0] KIND_MINUS  = 5'd4;
    localparam logic [4:0] KIND_SLASH  = 5'd5;
    localparam logic [4:0] KIND_PCT    = 5'd6;
    localparam logic [4:0] KIND_COMMA  = 5'd7;
    localparam logic [4:0] KIND_COLON  = 5'd8;
    localparam logic [4:0] KIND_SEMI   = 5'd9;
    localparam logic [4:0] KIND_LPAR   = 5'd10;
    localparam logic [4:0] KIND_RPAR   = 5'd11;
    localparam logic [4:0] KIND_LBRK   = 5'd12;
    localparam logic [4:0] KIND_RBRK   = 5'd13;
    localparam logic [4:0] KIND_LBRC   = 5'd14;
    localparam logic [4:0] KIND_RBRC   = 5'd15;
    localparam logic [4:0] KIND_EQ     = 5'd16;
    localparam logic [4:0] KIND_VAR    = 5'd17;
    localparam logic [4:0] KIND_FUNC   = 5'd18;
    localparam logic [4:0] KIND_EOF    = 5'd19;
    localparam logic [4:0] KIND_ERROR  = 5'd20;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BYTE     = 2'd1;
    localparam logic [1:0] ERR_POOL     = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic [1:0] OP_TOKEN = 2'd0;
    localparam logic [1:0] OP_IDENT = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic [4:0]                 kind;
        logic [31:0]                line;
        logic [62:0]                num;
        logic [1:0]                 err;
        logic [LEN_W-1:0]           len;
        logic [MAX_NAME-1:0][7:0]   name;
        logic                       item_last;
        logic                       text_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic idle;
        logic fail;
    } back_stat_t;

endpackage

FILE: hdl/stnp_if.sv
// Handshake interfaces for text bytes and tokens.
`timescale 1ns / 1ps
interface stnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
    modport source (output valid, text_byte, byte_present, end_of_text, input ready);
    modport sink (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

interface stnp_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] line_number;
    logic [62:0] number_value;
    logic [11:0] name_offset;
    logic [5:0]  name_length;
    logic [1:0]  error_code;
    logic        last_of_run;
    modport source (output valid, token_kind, line_number, number_value, name_offset,
                    name_length, error_code, last_of_run, input ready);
    modport sink (input valid, token_kind, line_number, number_value, name_offset,
                  name_length, error_code, last_of_run, output ready);
endinterface

FILE: hdl/source_tokenizer_with_name_pool_unit.sv
// Top level: front end, command queue and name pool back end.
// Simple tokens pass from the front end through the command queue to the back end's token
// register; identifiers search the pool byte by byte on the single read port, and a new name
// is written byte by byte. A byte is taken only once all earlier commands have finished in
// the back end, so no new byte is taken while the commands of the last one are in flight.
// Reset: rst_n clears all control state; line count restarts at 1 and the pool is empty.
`timescale 1ns / 1ps
module source_tokenizer_with_name_pool_unit
(
    input  logic        clk,
    input  logic        rst_n,
    stnp_in_if.sink     text_in,
    stnp_tok_if.source  token_out
);

    logic                  push;
    logic                  pop;
    stnp_pkg::cmd_t        push_data;
    stnp_pkg::cmd_t        head;
    stnp_pkg::fifo_stat_t  fifo_stat;
    stnp_pkg::back_stat_t  back_stat;
    logic                  sys_idle;

    assign sys_idle = fifo_stat.empty && back_stat.idle;

    stnp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .sys_idle  (sys_idle),
        .back_stat (back_stat),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    stnp_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    stnp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .stat      (back_stat),
        .token_out (token_out)
    );

endmodule

FILE: hdl/stnp_front.sv
// Front end: classifies text bytes and issues token commands to the queue.
`timescale 1ns / 1ps
module stnp_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    stnp_in_if.sink                text_in,
    input  logic                   sys_idle,
    input  stnp_pkg::back_stat_t   back_stat,
    input  stnp_pkg::fifo_stat_t   fifo_stat,
    output logic                   push,
    output stnp_pkg::cmd_t         push_data
);

    localparam logic [7:0] CH_V = 8'h76;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_US = 8'h5F;
    localparam logic [7:0] CH_0 = 8'h30;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_NUM   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;

    logic [31:0]                          line_reg, line_next;
    logic [1:0]                           mode_reg, mode_next;
    logic [62:0]                          acc_reg, acc_next;
    logic [stnp_pkg::LEN_W-1:0]           len_reg, len_next;
    logic [stnp_pkg::MAX_NAME-1:0][7:0]   buf_reg, buf_next;
    logic                                 fail_reg, fail_next;
    stnp_pkg::cmd_t                       list_reg [3];
    stnp_pkg::cmd_t                       list_next [3];
    logic [1:0]                           cnt_reg, cnt_next;
    logic [1:0]                           idx_reg;
    logic                                 busy_reg;
    logic                                 accept;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               is_digit(c) || (c == CH_US);
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = stnp_pkg::KIND_PLUS;
            8'h2A:   k = stnp_pkg::KIND_STAR;
            8'h2D:   k = stnp_pkg::KIND_MINUS;
            8'h2F:   k = stnp_pkg::KIND_SLASH;
            8'h25:   k = stnp_pkg::KIND_PCT;
            8'h2C:   k = stnp_pkg::KIND_COMMA;
            8'h3A:   k = stnp_pkg::KIND_COLON;
            8'h3B:   k = stnp_pkg::KIND_SEMI;
            8'h28:   k = stnp_pkg::KIND_LPAR;
            8'h29:   k = stnp_pkg::KIND_RPAR;
            8'h5B:   k = stnp_pkg::KIND_LBRK;
            8'h5D:   k = stnp_pkg::KIND_RBRK;
            8'h7B:   k = stnp_pkg::KIND_LBRC;
            8'h7D:   k = stnp_pkg::KIND_RBRC;
            8'h3D:   k = stnp_pkg::KIND_EQ;
            default: k = stnp_pkg::KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic stnp_pkg::cmd_t token_cmd(input logic [4:0] kind, input logic [31:0] line,
                                                 input logic [62:0] num, input logic [1:0] err);
        stnp_pkg::cmd_t r;
        r      = '0;
        r.op   = stnp_pkg::OP_TOKEN;
        r.kind = kind;
        r.line = line;
        r.num  = num;
        r.err  = err;
        return r;
    endfunction

    function automatic stnp_pkg::cmd_t flush_cmd(input logic [1:0] mode, input logic [62:0] acc,
                                                 input logic [stnp_pkg::LEN_W-1:0] len,
                                                 input logic [stnp_pkg::MAX_NAME-1:0][7:0] nb,
                                                 input logic [31:0] line);
        stnp_pkg::cmd_t r;
        if (mode == MODE_NUM)
        begin
            r = token_cmd(stnp_pkg::KIND_NUMBER, line, acc, stnp_pkg::ERR_NONE);
        end
        else if (len == 6'd3 && nb[0] == CH_V && nb[1] == CH_A && nb[2] == CH_R)
        begin
            r = token_cmd(stnp_pkg::KIND_VAR, line, '0, stnp_pkg::ERR_NONE);
        end
        else if (len == 6'd4 && nb[0] == CH_F && nb[1] == CH_U && nb[2] == CH_N && nb[3] == CH_C)
        begin
            r = token_cmd(stnp_pkg::KIND_FUNC, line, '0, stnp_pkg::ERR_NONE);
        end
        else
        begin
            r      = '0;
            r.op   = stnp_pkg::OP_IDENT;
            r.kind = stnp_pkg::KIND_IDENT;
            r.line = line;
            r.len  = len;
            r.name = nb;
        end
        return r;
    endfunction

    assign accept = text_in.valid && text_in.ready;
    assign text_in.ready = !busy_reg && sys_idle;

    always_comb
    begin
        logic [7:0]  c;
        logic        ok;
        logic [1:0]  n;
        logic [66:0] prod;
        logic [4:0]  ok_kind;
        c         = text_in.text_byte;
        ok        = 1'b1;
        n         = 2'd0;
        prod      = '0;
        ok_kind   = op_kind(c);
        line_next = line_reg;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        len_next  = len_reg;
        buf_next  = buf_reg;
        fail_next = fail_reg;
        for (int k = 0; k < 3; k++)
        begin
            list_next[k] = '0;
        end
        if (fail_reg || back_stat.fail)
        begin
            if (text_in.end_of_text)
            begin
                list_next[0]    = '0;
                list_next[0].op = stnp_pkg::OP_RESET;
                n               = 2'd1;
            end
        end
        else
        begin
            if (text_in.byte_present)
            begin
                if (mode_next == MODE_NUM && is_digit(c))
                begin
                    prod = ({4'b0, acc_next} << 3) + ({4'b0, acc_next} << 1) +
                           {59'b0, c - CH_0};
                    acc_next = (prod > {4'b0, stnp_pkg::NUM_MAX}) ? stnp_pkg::NUM_MAX
                                                                  : prod[62:0];
                end
                else if (mode_next == MODE_IDENT && is_ident(c))
                begin
                    if (len_next < 6'(stnp_pkg::MAX_NAME))
                    begin
                        buf_next[len_next[stnp_pkg::NAME_AW-1:0]] = c;
                        len_next = len_next + 6'd1;
                    end
                    else
                    begin
                        mode_next = MODE_NONE;
                        list_next[n] = token_cmd(stnp_pkg::KIND_ERROR, line_next, '0,
                                                 stnp_pkg::ERR_TOO_LONG);
                        n  = n + 2'd1;
                        ok = 1'b0;
                    end
                end
                else
                begin
                    if (mode_next != MODE_NONE)
                    begin
                        list_next[n] = flush_cmd(mode_next, acc_next, len_next, buf_next,
                                                 line_next);
                        n = n + 2'd1;
                        mode_next = MODE_NONE;
                    end
                    if (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D})
                    begin
                        if (c == CH_NL && line_next != stnp_pkg::LINE_MAX)
                        begin
                            line_next = line_next + 32'd1;
                        end
                    end
                    else if (ok_kind != stnp_pkg::KIND_IDENT)
                    begin
                        list_next[n] = token_cmd(ok_kind, line_next, '0, stnp_pkg::ERR_NONE);
                        n = n + 2'd1;
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = MODE_NUM;
                        acc_next  = {55'b0, c - CH_0};
                    end
                    else if (is_ident(c))
                    begin
                        mode_next   = MODE_IDENT;
                        buf_next[0] = c;
                        len_next    = 6'd1;
                    end
                    else
                    begin
                        list_next[n] = token_cmd(stnp_pkg::KIND_ERROR, line_next, '0,
                                                 stnp_pkg::ERR_BYTE);
                        n  = n + 2'd1;
                        ok = 1'b0;
                    end
                end
            end
            if (ok && text_in.end_of_text)
            begin
                if (mode_next != MODE_NONE)
                begin
                    list_next[n] = flush_cmd(mode_next, acc_next, len_next, buf_next, line_next);
                    n = n + 2'd1;
                end
                list_next[n] = token_cmd(stnp_pkg::KIND_EOF, line_next, '0, stnp_pkg::ERR_NONE);
                n = n + 2'd1;
            end
            if (!ok && !text_in.end_of_text)
            begin
                fail_next = 1'b1;
                mode_next = MODE_NONE;
            end
        end
        if (n != 2'd0)
        begin
            list_next[n - 2'd1].item_last = 1'b1;
            list_next[n - 2'd1].text_end  = text_in.end_of_text;
        end
        if (text_in.end_of_text)
        begin
            line_next = 32'd1;
            mode_next = MODE_NONE;
            acc_next  = '0;
            len_next  = '0;
            fail_next = 1'b0;
        end
        cnt_next = n;
    end

    assign push      = busy_reg && !fifo_stat.full;
    assign push_data = list_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= 32'd1;
            mode_reg <= MODE_NONE;
            acc_reg  <= '0;
            len_reg  <= '0;
            fail_reg <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            line_reg <= line_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            len_reg  <= len_next;
            fail_reg <= fail_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= '0;
            busy_reg <= (cnt_next != 2'd0);
        end
        else if (push)
        begin
            idx_reg <= idx_reg + 2'd1;
            if (idx_reg == cnt_reg - 2'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
            for (int k = 0; k < 3; k++)
            begin
                list_reg[k] <= list_next[k];
            end
        end
    end

endmodule

FILE: hdl/stnp_fifo.sv
// Two-entry command queue between front and back ends.
`timescale 1ns / 1ps
module stnp_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  stnp_pkg::cmd_t        push_data,
    input  logic                  pop,
    output stnp_pkg::cmd_t        head,
    output stnp_pkg::fifo_stat_t  stat
);

    stnp_pkg::cmd_t  mem_reg [2];
    logic            wr_reg;
    logic            rd_reg;
    logic [1:0]      cnt_reg;

    assign head       = mem_reg[rd_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/stnp_back.sv
// Back end: interns identifiers in the name pool and drives the token register.
`timescale 1ns / 1ps
module stnp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stnp_pkg::cmd_t        head,
    input  stnp_pkg::fifo_stat_t  fifo_stat,
    output logic                  pop,
    output stnp_pkg::back_stat_t  stat,
    stnp_tok_if.source            token_out
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_REQ  = 3'd1;
    localparam logic [2:0] B_CMP  = 3'd2;
    localparam logic [2:0] B_NF   = 3'd3;
    localparam logic [2:0] B_WR   = 3'd4;
    localparam logic [2:0] B_EMIT = 3'd5;

    logic [2:0]                     state_reg;
    stnp_pkg::cmd_t                 cmd_reg;
    logic [stnp_pkg::FILL_W-1:0]    i_reg;
    logic [stnp_pkg::LEN_W-1:0]     j_reg;
    logic [stnp_pkg::FILL_W-1:0]    fill_reg;
    logic                           fail_reg;
    logic                           skip_reg;
    logic                           err_reg;
    logic [11:0]                    off_reg;
    logic [7:0]                     pool_mem [stnp_pkg::POOL_BYTES];
    logic [7:0]                     rd_reg;
    logic [stnp_pkg::POOL_AW-1:0]   rd_addr;
    logic [stnp_pkg::POOL_AW-1:0]   wr_addr;
    logic [stnp_pkg::FILL_W:0]      next_end;
    logic [stnp_pkg::FILL_W:0]      pool_end;
    logic                           out_free;
    logic [7:0]                     name_byte;

    assign pop        = (state_reg == B_IDLE) && !fifo_stat.empty;
    assign stat.idle  = (state_reg == B_IDLE);
    assign stat.fail  = fail_reg;
    assign rd_addr    = i_reg[stnp_pkg::POOL_AW-1:0] + stnp_pkg::POOL_AW'(j_reg);
    assign wr_addr    = fill_reg[stnp_pkg::POOL_AW-1:0] + stnp_pkg::POOL_AW'(j_reg);
    assign next_end   = {1'b0, i_reg} + 14'd1 + 14'(cmd_reg.len);
    assign pool_end   = {1'b0, fill_reg} + 14'(cmd_reg.len);
    assign out_free   = !token_out.valid || token_out.ready;
    assign name_byte  = cmd_reg.name[j_reg[stnp_pkg::NAME_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (state_reg == B_WR)
        begin
            pool_mem[wr_addr] <= name_byte;
        end
        rd_reg <= pool_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            fill_reg        <= '0;
            fail_reg        <= 1'b0;
            skip_reg        <= 1'b0;
            token_out.valid <= 1'b0;
        end
        else
        begin
            if (token_out.valid && token_out.ready)
            begin
                token_out.valid <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg <= head;
                        i_reg   <= '0;
                        j_reg   <= '0;
                        err_reg <= 1'b0;
                        off_reg <= '0;
                        if (skip_reg)
                        begin
                            if (head.item_last)
                            begin
                                skip_reg <= 1'b0;
                                if (head.text_end)
                                begin
                                    fill_reg <= '0;
                                    fail_reg <= 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            case (head.op)
                                stnp_pkg::OP_RESET:
                                begin
                                    fill_reg <= '0;
                                    fail_reg <= 1'b0;
                                end
                                stnp_pkg::OP_IDENT:
                                begin
                                    state_reg <= (14'(head.len) > {1'b0, fill_reg}) ? B_NF
                                                                                  : B_REQ;
                                end
                                default:
                                begin
                                    state_reg <= B_EMIT;
                                end
                            endcase
                        end
                    end
                end
                B_REQ:
                begin
                    state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (rd_reg == name_byte)
                    begin
                        if (j_reg == cmd_reg.len - 6'd1)
                        begin
                            off_reg   <= i_reg[11:0];
                            state_reg <= B_EMIT;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 6'd1;
                            state_reg <= B_REQ;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 13'd1;
                        j_reg     <= '0;
                        state_reg <= (next_end > {1'b0, fill_reg}) ? B_NF : B_REQ;
                    end
                end
                B_NF:
                begin
                    j_reg <= '0;
                    if (pool_end > 14'(stnp_pkg::POOL_BYTES))
                    begin
                        err_reg   <= 1'b1;
                        fail_reg  <= 1'b1;
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        state_reg <= B_WR;
                    end
                end
                B_WR:
                begin
                    if (j_reg == cmd_reg.len - 6'd1)
                    begin
                        off_reg   <= fill_reg[11:0];
                        fill_reg  <= pool_end[stnp_pkg::FILL_W-1:0];
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 6'd1;
                    end
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        token_out.valid <= 1'b1;
                        state_reg       <= B_IDLE;
                        if (err_reg && !cmd_reg.item_last)
                        begin
                            skip_reg <= 1'b1;
                        end
                        if (cmd_reg.item_last && cmd_reg.text_end)
                        begin
                            fill_reg <= '0;
                            fail_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_EMIT && out_free)
        begin
            token_out.line_number <= cmd_reg.line;
            token_out.last_of_run <= cmd_reg.item_last || err_reg;
            if (err_reg)
            begin
                token_out.token_kind   <= stnp_pkg::KIND_ERROR;
                token_out.number_value <= '0;
                token_out.name_offset  <= '0;
                token_out.name_length  <= '0;
                token_out.error_code   <= stnp_pkg::ERR_POOL;
            end
            else
            begin
                token_out.token_kind   <= cmd_reg.kind;
                token_out.number_value <= cmd_reg.num;
                token_out.name_offset  <= off_reg;
                token_out.name_length  <= cmd_reg.len;
                token_out.error_code   <= cmd_reg.err;
            end
        end
    end

endmodule

FILE: hdl/stnp_checker.sv
// Port-level checks of the token output, bound to the top level.
`timescale 1ns / 1ps
module stnp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  kind,
    input logic [5:0]  name_length,
    input logic [1:0]  error_code,
    input logic [62:0] number_value
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token valid dropped while stalled");

    a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind))
        else $error("token kind changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= stnp_pkg::KIND_ERROR)
        else $error("token kind out of range");

    a_len_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != stnp_pkg::KIND_IDENT |-> name_length == 6'd0)
        else $error("name length on non-identifier");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != stnp_pkg::ERR_NONE |->
        kind == stnp_pkg::KIND_ERROR && number_value == 63'd0)
        else $error("error code on non-error token");

endmodule

bind source_tokenizer_with_name_pool_unit stnp_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (token_out.valid),
    .out_ready    (token_out.ready),
    .kind         (token_out.token_kind),
    .name_length  (token_out.name_length),
    .error_code   (token_out.error_code),
    .number_value (token_out.number_value)
);

FILE: tb/source_tokenizer_with_name_pool_unit_tb.sv
// Testbench for the source tokenizer: directed and random texts checked against a predictor.
`timescale 1ns / 1ps
module source_tokenizer_with_name_pool_unit_tb;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] line;
        logic [62:0] num;
        logic [11:0] off;
        logic [5:0]  len;
        logic [1:0]  err;
        logic        last;
    } token_t;

    localparam int WATCHDOG_LIMIT = 400000;

    logic clk;
    logic rst_n;
    stnp_in_if  text_in ();
    stnp_tok_if token_out ();

    source_tokenizer_with_name_pool_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in.sink),
        .token_out (token_out.sink)
    );

    // predictor state
    logic [31:0] lines;
    logic [1:0]  mode;
    logic [62:0] acc;
    logic [7:0]  nbuf [stnp_pkg::MAX_NAME];
    int          nlen;
    logic [7:0]  pool [stnp_pkg::POOL_BYTES];
    int          fill;
    logic        failed;

    token_t tok_q [$];
    token_t run_q [$];
    int     mismatches;
    int     tokens_seen;
    int     bytes_sent;
    int     idle_pct;
    int     hold_off;
    int     quiet;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic lexer_reset();
        lines  = 32'd1;
        mode   = 2'd0;
        acc    = '0;
        nlen   = 0;
        fill   = 0;
        failed = 1'b0;
    endtask

    function automatic void push_tok(logic [4:0] kind, logic [62:0] num, int off, int len,
                                     logic [1:0] err);
        token_t t;
        t.kind = kind;
        t.line = lines;
        t.num  = num;
        t.off  = off[11:0];
        t.len  = len[5:0];
        t.err  = err;
        t.last = 1'b0;
        run_q.push_back(t);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_name(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
    endfunction

    function automatic bit buf_is(string w);
        if (nlen != w.len())
            return 0;
        for (int i = 0; i < nlen; i++)
            if (nbuf[i] != w[i])
                return 0;
        return 1;
    endfunction

    function automatic bit flush_name();
        int m;
        bit hit;
        m = mode;
        mode = 2'd0;
        if (m == 1)
            push_tok(stnp_pkg::KIND_NUMBER, acc, 0, 0, stnp_pkg::ERR_NONE);
        else if (m == 2)
        begin
            if (buf_is("var"))
            begin
                push_tok(stnp_pkg::KIND_VAR, '0, 0, 0, stnp_pkg::ERR_NONE);
                return 1;
            end
            if (buf_is("func"))
            begin
                push_tok(stnp_pkg::KIND_FUNC, '0, 0, 0, stnp_pkg::ERR_NONE);
                return 1;
            end
            for (int i = 0; i + nlen <= fill; i++)
            begin
                hit = 1;
                for (int j = 0; j < nlen; j++)
                    if (pool[i + j] != nbuf[j])
                        hit = 0;
                if (hit)
                begin
                    push_tok(stnp_pkg::KIND_IDENT, '0, i, nlen, stnp_pkg::ERR_NONE);
                    return 1;
                end
            end
            if (fill + nlen > stnp_pkg::POOL_BYTES)
            begin
                push_tok(stnp_pkg::KIND_ERROR, '0, 0, 0, stnp_pkg::ERR_POOL);
                return 0;
            end
            for (int j = 0; j < nlen; j++)
                pool[fill + j] = nbuf[j];
            push_tok(stnp_pkg::KIND_IDENT, '0, fill, nlen, stnp_pkg::ERR_NONE);
            fill += nlen;
        end
        return 1;
    endfunction

    function automatic bit start_byte(logic [7:0] c);
        string ops;
        ops = "+*-/%,:;()[]{}=";
        if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D)
        begin
            if (c == 8'h0A && lines != stnp_pkg::LINE_MAX)
                lines++;
            return 1;
        end
        for (int k = 0; k < 15; k++)
            if (ops[k] == c)
            begin
                push_tok(stnp_pkg::KIND_PLUS + 5'(k), '0, 0, 0, stnp_pkg::ERR_NONE);
                return 1;
            end
        if (is_digit(c))
        begin
            mode = 2'd1;
            acc = 63'(c - "0");
            return 1;
        end
        if (is_name(c))
        begin
            mode = 2'd2;
            nbuf[0] = c;
            nlen = 1;
            return 1;
        end
        push_tok(stnp_pkg::KIND_ERROR, '0, 0, 0, stnp_pkg::ERR_BYTE);
        return 0;
    endfunction

    task automatic predict_tokens(logic [7:0] c, logic present, logic eot);
        bit ok;
        logic [62:0] d;
        ok = 1;
        run_q.delete();
        if (failed)
        begin
            if (eot)
                lexer_reset();
            return;
        end
        if (present)
        begin
            if (mode == 1 && is_digit(c))
            begin
                d = 63'(c - "0");
                if (acc > (stnp_pkg::NUM_MAX - d) / 10)
                    acc = stnp_pkg::NUM_MAX;
                else
                    acc = acc * 10 + d;
            end
            else if (mode == 2 && is_name(c))
            begin
                if (nlen < stnp_pkg::MAX_NAME)
                begin
                    nbuf[nlen] = c;
                    nlen++;
                end
                else
                begin
                    mode = 2'd0;
                    push_tok(stnp_pkg::KIND_ERROR, '0, 0, 0, stnp_pkg::ERR_TOO_LONG);
                    ok = 0;
                end
            end
            else
            begin
                ok = flush_name();
                if (ok)
                    ok = start_byte(c);
            end
        end
        if (ok && eot)
        begin
            ok = flush_name();
            if (ok)
                push_tok(stnp_pkg::KIND_EOF, '0, 0, 0, stnp_pkg::ERR_NONE);
        end
        if (eot)
            lexer_reset();
        else if (!ok)
        begin
            failed = 1'b1;
            mode = 2'd0;
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            tok_q.push_back(run_q[i]);
    endtask

    task automatic send_byte(logic [7:0] c, logic present = 1'b1, logic eot = 1'b0);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            text_in.valid <= 1'b0;
            @(posedge clk);
        end
        text_in.valid        <= 1'b1;
        text_in.text_byte    <= c;
        text_in.byte_present <= present;
        text_in.end_of_text  <= eot;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        predict_tokens(c, present, eot);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit eot = 1);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b1, eot && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        text_in.valid <= 1'b0;
        while (tok_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_char();
        string alpha;
        string ops;
        int r;
        alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        ops = "+*-/%,:;()[]{}=";
        r = $urandom_range(99);
        if (r < 40)
            return alpha[$urandom_range(alpha.len() - 1)];
        if (r < 55)
            return 8'("0" + $urandom_range(9));
        if (r < 75)
            return " ";
        if (r < 82)
            return 8'h0A;
        if (r < 97)
            return ops[$urandom_range(14)];
        return 8'($urandom_range(255));
    endfunction

    task automatic test_operators();
        send_text("+*-/%,:;()[]{}=");
        send_text(" \t\v\f\r\n+\n;");
    endtask

    task automatic test_numbers();
        send_text("0 9223372036854775807 99999999999999999999+7");
    endtask

    task automatic test_names();
        send_text("var func vars fun abc bc abc _Z9");
        send_text("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa x");
        send_text("a#b c");
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random();
        int items;
        items = 0;
        while (items < 80)
        begin
            idle_pct = (items > 20 && items < 60) ? 0 : 12;
            send_byte(rand_char(), 1'b1, $urandom_range(39) == 0);
            items++;
        end
        send_byte(" ", 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_text("a1 b2 c3 + - 42 zz zz var", 1);
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_out.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            token_out.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            token_out.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n && token_out.valid && token_out.ready)
        begin
            got.kind = token_out.token_kind;
            got.line = token_out.line_number;
            got.num  = token_out.number_value;
            got.off  = token_out.name_offset;
            got.len  = token_out.name_length;
            got.err  = token_out.error_code;
            got.last = token_out.last_of_run;
            tokens_seen++;
            if (tok_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token %p", got);
            end
            else
            begin
                want = tok_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_in.valid && text_in.ready) || (token_out.valid && token_out.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d tokens outstanding", tok_q.size());
            $display("FAIL source_tokenizer_with_name_pool_unit");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        tokens_seen = 0;
        bytes_sent = 0;
        idle_pct = 12;
        hold_off = 0;
        quiet = 0;
        rst_n = 1'b0;
        text_in.valid = 1'b0;
        text_in.text_byte = '0;
        text_in.byte_present = 1'b0;
        text_in.end_of_text = 1'b0;
        lexer_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_numbers();
        test_names();
        wait_drained();
        test_backpressure();
        test_random();
        wait_drained();
        $display("bytes sent %0d, tokens checked %0d, mismatches %0d",
                 bytes_sent, tokens_seen, mismatches);
        $display("covered operators, keywords, saturation, interning, stalls and byte errors");
        if (mismatches == 0 && tok_q.size() == 0)
            $display("PASS source_tokenizer_with_name_pool_unit");
        else
            $display("FAIL source_tokenizer_with_name_pool_unit");
        $finish;
    end
endmodule
